/* hw/rtl/utf8d_pkg.sv */
// ----------------------------------------------------------------------------
// utf8d_pkg: shared types and constants for the UTF-8 decoder
// Byte class limits, the replacement code point and the sequence state
// record passed between the decode step and the top level.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int unsigned CP_W = 21;

  localparam logic [CP_W-1:0] REPLACEMENT = 21'h00FFFD;

  // byte class limits
  localparam logic [7:0] FOLLOW_LO = 8'h80;
  localparam logic [7:0] FOLLOW_HI = 8'hBF;
  localparam logic [7:0] LEAD2_HI  = 8'hDF;
  localparam logic [7:0] LEAD3_HI  = 8'hEF;

  // follower counts
  localparam logic [1:0] NEED_NONE  = 2'd0;
  localparam logic [1:0] NEED_ONE   = 2'd1;
  localparam logic [1:0] NEED_TWO   = 2'd2;
  localparam logic [1:0] NEED_THREE = 2'd3;

  // pending sequence
  typedef struct packed {
    logic [7:0]  lead;
    logic [1:0]  need;       // followers still to come, zero when idle
    logic [23:0] gathered;   // followers so far, newest in the low byte
  } seq_state_t;

  // result of one byte
  typedef struct packed {
    logic            valid;
    logic [CP_W-1:0] code_point;
    logic            bad;
  } step_result_t;

  function automatic logic is_follower(input logic [7:0] b);
    return (b >= FOLLOW_LO) && (b <= FOLLOW_HI);
  endfunction

endpackage

/* hw/rtl/utf8d_step.sv */
// ----------------------------------------------------------------------------
// utf8d_step: one-byte decode step
// From the pending sequence and one byte, forms the next sequence state
// and, when the byte ends a sequence or is a literal, the code point.
// ----------------------------------------------------------------------------
module utf8d_step (
  input  utf8d_pkg::seq_state_t   cur,
  input  logic [7:0]              data_byte,
  input  logic                    line_end,
  output utf8d_pkg::seq_state_t   nxt,
  output utf8d_pkg::step_result_t res
);
  import utf8d_pkg::*;

  logic [23:0]     gath_shift;
  logic [1:0]      need_dec;
  logic [7:0]      f0, f1, f2;
  logic [CP_W-1:0] cp_done;
  logic [CP_W-1:0] cp_out;

  assign gath_shift = {cur.gathered[15:0], data_byte};
  assign need_dec   = cur.need - NEED_ONE;

  // value of a completed sequence, taken from the shifted followers
  always_comb begin
    f0 = 8'h00;
    f1 = 8'h00;
    f2 = 8'h00;
    cp_done = REPLACEMENT;
    if (cur.lead <= LEAD2_HI) begin
      f0 = gath_shift[7:0];
      if (is_follower(f0)) begin
        cp_done = CP_W'({cur.lead[4:0], f0[5:0]});
      end
    end else if (cur.lead <= LEAD3_HI) begin
      f0 = gath_shift[15:8];
      f1 = gath_shift[7:0];
      if (is_follower(f0) && is_follower(f1)) begin
        cp_done = CP_W'({cur.lead[3:0], f0[5:0], f1[5:0]});
      end
    end else begin
      f0 = gath_shift[23:16];
      f1 = gath_shift[15:8];
      f2 = gath_shift[7:0];
      if (is_follower(f0) && is_follower(f1) && is_follower(f2)) begin
        cp_done = {cur.lead[2:0], f0[5:0], f1[5:0], f2[5:0]};
      end
    end
  end

  // sequence tracking
  always_comb begin
    nxt       = cur;
    res.valid = 1'b0;
    cp_out    = REPLACEMENT;
    if (cur.need == NEED_NONE) begin
      if (data_byte < FOLLOW_LO) begin
        res.valid = 1'b1;
        cp_out    = CP_W'(data_byte);
      end else if (data_byte <= FOLLOW_HI) begin
        // stray continuation
        res.valid = 1'b1;
      end else begin
        nxt.lead     = data_byte;
        nxt.gathered = 24'h000000;
        if (data_byte <= LEAD2_HI) begin
          nxt.need = NEED_ONE;
        end else if (data_byte <= LEAD3_HI) begin
          nxt.need = NEED_TWO;
        end else begin
          nxt.need = NEED_THREE;
        end
        if (line_end) begin
          // lead byte cut off by the line end
          nxt.need  = NEED_NONE;
          res.valid = 1'b1;
        end
      end
    end else begin
      nxt.gathered = gath_shift;
      nxt.need     = need_dec;
      if (need_dec == NEED_NONE) begin
        nxt.gathered = 24'h000000;
        res.valid    = 1'b1;
        cp_out       = cp_done;
      end else if (line_end) begin
        // sequence cut off by the line end
        nxt.need     = NEED_NONE;
        nxt.gathered = 24'h000000;
        res.valid    = 1'b1;
      end
    end
    res.code_point = cp_out;
    res.bad        = (cp_out == REPLACEMENT);
  end

endmodule

/* hw/rtl/utf8_byte_to_codepoint_decoder.sv */
// ----------------------------------------------------------------------------
// utf8_byte_to_codepoint_decoder: UTF-8 byte stream to code points
//
//   channel  dir  tdata (low bit up)       tlast     tuser
//   s_axis   in   data_byte[7:0]           line_end  -
//   m_axis   out  code_point[20:0], 3'b0   -         bad_sequence
//
// One byte is taken per cycle while the output does not stall. A byte is
// first captured in the input register, then the decode step updates the
// sequence state and loads the result register with the code point.
// Reset clears the pending sequence and both valid flags. A stall on the
// output holds the byte in the input register; a byte that yields no code
// point still waits for a free result slot, which keeps the logic short.
// ----------------------------------------------------------------------------
module utf8_byte_to_codepoint_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // line_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] zero
  output logic        m_tuser    // [0] bad_sequence
);
  import utf8d_pkg::*;

  logic         a_valid;
  logic [7:0]   a_byte;
  logic         a_last;
  logic         res_free;
  logic         a_adv;
  seq_state_t   st;
  seq_state_t   st_next;
  step_result_t step_res;
  logic [CP_W-1:0] out_cp;
  logic         out_bad;

  assign res_free = !m_tvalid || m_tready;
  assign a_adv    = a_valid && res_free;
  assign s_tready = !a_valid || a_adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_tready) begin
      a_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      a_byte <= s_tdata;
      a_last <= s_tlast;
    end
  end

  utf8d_step u_step (
    .cur       (st),
    .data_byte (a_byte),
    .line_end  (a_last),
    .nxt       (st_next),
    .res       (step_res)
  );

  // sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      st.need     <= NEED_NONE;
      st.lead     <= 8'h00;
      st.gathered <= 24'h000000;
    end else if (a_adv) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_free) begin
      m_tvalid <= a_valid && step_res.valid;
    end
    if (a_adv && step_res.valid) begin
      out_cp  <= step_res.code_point;
      out_bad <= step_res.bad;
    end
  end

  assign m_tdata = {3'b000, out_cp};
  assign m_tuser = out_bad;

  // flag marks exactly the replacement value
  a_flag_matches: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == (m_tdata[CP_W-1:0] == REPLACEMENT)))
    else $error("bad_sequence disagrees with code point");

  // a line end always leaves the decoder idle
  a_line_end_idle: assert property (@(posedge clk) disable iff (rst)
    (a_adv && a_last) |=> (st.need == NEED_NONE))
    else $error("sequence still pending after line end");

  // an empty input register never blocks the input
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !a_valid |-> s_tready)
    else $error("input stalled with empty input register");

  // a held byte stays put while the result slot is full
  a_hold_byte: assert property (@(posedge clk) disable iff (rst)
    (a_valid && !res_free) |=> (a_valid && $stable(a_byte) && $stable(a_last)))
    else $error("held input byte changed during stall");

  // sequence state moves only when a byte is decoded
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !a_adv |=> $stable(st.need))
    else $error("sequence state changed without a byte");

endmodule
